// File: rtl/idm_pkg.sv
// Shared types and constants for the car-following route step block.
`timescale 1ns / 1ps
`default_nettype none

package idm_pkg;

    // Shared divider widths: dividend and divisor
    localparam int DIVN_W = 42;
    localparam int DIVD_W = 25;

    // Penalty terms are held at 2^33
    localparam int PEN_W = 34;
    localparam logic [PEN_W-1:0] PEN_CAP = 34'h2_0000_0000;

    // Item kinds carried in tuser
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_MIN_GAP       = 3'd0;
    localparam logic [2:0] REG_REACTION_TIME = 3'd1;
    localparam logic [2:0] REG_MAX_ACCEL     = 3'd2;
    localparam logic [2:0] REG_BRAKE_COEF    = 3'd3;
    localparam logic [2:0] REG_SAMPLE_TIME   = 3'd4;
    localparam logic [2:0] REG_ROUTE_LENGTH  = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_GAP,
        S_RDIV,
        S_R2,
        S_R4,
        S_QSTART,
        S_QDIV,
        S_Q2,
        S_F,
        S_UPD,
        S_ADV,
        S_WRD,
        S_WCHK,
        S_WDIV,
        S_DONE
    } idm_state_t;

    typedef struct packed {
        logic              start;
        logic [DIVN_W-1:0] dividend;
        logic [DIVD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// File: rtl/idm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module idm_ram #(
    parameter int Width = 8,
    parameter int Depth = 16,
    parameter int AddrW = $clog2(Depth)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [Width-1:0] wdata,
    input  logic [AddrW-1:0] raddr,
    output logic [Width-1:0] rdata
);

    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/idm_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module idm_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  idm_pkg::div_req_t                req,
    output idm_pkg::div_stat_t               stat,
    output logic [idm_pkg::DIVN_W-1:0]       quotient
);

    import idm_pkg::*;

    localparam int CNT_W = $clog2(DIVN_W);

    logic [DIVN_W-1:0] num_reg, num_next;
    logic [DIVD_W-1:0] rem_reg, rem_next;
    logic [DIVD_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIVD_W:0]   shifted;
    logic [DIVD_W:0]   diff;
    logic              ge;

    always_comb
    begin
        shifted  = {rem_reg, num_reg[DIVN_W-1]};
        ge       = shifted >= {1'b0, dvs_reg};
        diff     = shifted - {1'b0, dvs_reg};
        rem_next = ge ? diff[DIVD_W-1:0] : shifted[DIVD_W-1:0];
        num_next = {num_reg[DIVN_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVN_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = num_reg;

endmodule

`default_nettype wire

// File: rtl/idm_car_following_route_step.sv
// Top level: intelligent driver model vehicle stepping along a stored route.
//
//  channel  | dir | transfer
//  ---------+-----+-------------------------------------------------------------
//  s_*      | in  | one load (write segment) or step item
//  m_*      | out | one result per item: speed, progress, segment, on_map
//  apb      | in  | register writes and reads, pready always high
//
// A step item runs up to 3 divisions on the shared one-bit-per-cycle divider and
// a route walk over the segments of the route, one RAM read per segment visited.
// Reset clears the car state and sets the configuration registers to their defaults;
// the route RAM is not cleared. A finished result waits in the output register while the next item is taken.
`timescale 1ns / 1ps
`default_nettype none

module idm_car_following_route_step #(
    parameter int MAX_SEGMENTS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // seg_index[7:0], seg_length[31:8], seg_speed_limit[47:32],
    // obstacle_distance[71:48], obstacle_speed[87:72]
    input  logic [87:0] s_tdata,
    // mode[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // car_speed[15:0], seg_progress[31:16], current_seg[40:32], on_map[41], zero[47:42]
    output logic [47:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import idm_pkg::*;

    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    // configuration
    logic [23:0] min_gap_reg;
    logic [23:0] react_reg;
    logic [15:0] accel_reg;
    logic [15:0] brake_reg;
    logic [15:0] dt_reg;
    logic [8:0]  rlen_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    // car state
    logic [15:0] speed_reg, speed_next;
    logic [15:0] prog_reg;
    logic [8:0]  seg_reg;

    idm_state_t  state_reg, state_next;

    // datapath registers
    logic [23:0] dist_reg;
    logic [15:0] vo_reg;
    logic [39:0] a_reg;
    logic [31:0] b_reg;
    logic [47:0] p_reg;
    logic        neg_reg;
    logic [15:0] lim_reg;
    logic [25:0] gap_reg;
    logic [31:0] r2_reg;
    logic [PEN_W-1:0] pv_reg, pg_reg;
    logic signed [35:0] f_reg, f_next;
    logic signed [17:0] upd_reg, upd_next;
    logic [33:0] adv_reg, adv_next;
    logic [8:0]  i_reg;
    logic        first_reg;

    // output register
    logic        m_tvalid_reg;
    logic [47:0] m_data_reg;

    // RAM
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [39:0]   ram_wdata, ram_rdata;

    // divider
    div_req_t          div_req;
    div_stat_t         div_stat;
    logic [DIVN_W-1:0] quot;

    // combinational terms
    logic        s_accept;
    logic [8:0]  n_eff;
    logic [8:0]  lim_idx;
    logic [15:0] absdiff;
    logic [47:0] at48;
    logic [48:0] extra;
    logic [25:0] gap_sum;
    logic [47:0] r_sq;
    logic [63:0] r4_full;
    logic [PEN_W-1:0] pv_r4;
    logic [49:0] q_sq;
    logic [PEN_W-1:0] pg_q2;
    logic signed [52:0] prod;
    logic signed [36:0] sh;
    logic signed [36:0] negv;
    logic signed [36:0] upd_c;
    logic [18:0] base;
    logic [18:0] ns;
    logic [23:0] len;
    logic [16:0] rem_frac;
    logic [41:0] d_val;
    logic        d_gt;
    logic        out_free;

    //------------------------------------------------------------------
    // APB registers
    //------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gap_reg <= 24'd512;
            react_reg   <= 24'd65536;
            accel_reg   <= 16'd256;
            brake_reg   <= 16'd32768;
            dt_reg      <= 16'd6554;
            rlen_reg    <= 9'd0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_MIN_GAP:       min_gap_reg <= pwdata[23:0];
                REG_REACTION_TIME: react_reg   <= pwdata[23:0];
                REG_MAX_ACCEL:     accel_reg   <= pwdata[15:0];
                REG_BRAKE_COEF:    brake_reg   <= pwdata[15:0];
                REG_SAMPLE_TIME:   dt_reg      <= pwdata[15:0];
                REG_ROUTE_LENGTH:  rlen_reg    <= pwdata[8:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_MIN_GAP:       prdata = {8'd0, min_gap_reg};
            REG_REACTION_TIME: prdata = {8'd0, react_reg};
            REG_MAX_ACCEL:     prdata = {16'd0, accel_reg};
            REG_BRAKE_COEF:    prdata = {16'd0, brake_reg};
            REG_SAMPLE_TIME:   prdata = {16'd0, dt_reg};
            REG_ROUTE_LENGTH:  prdata = {23'd0, rlen_reg};
            default:           prdata = 32'd0;
        endcase
    end

    //------------------------------------------------------------------
    // Route RAM: limit in the upper bits, length in the lower
    //------------------------------------------------------------------
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid & s_tready;

    assign n_eff   = (32'(rlen_reg) < 32'(MAX_SEGMENTS)) ? rlen_reg : 9'(MAX_SEGMENTS);
    assign lim_idx = (seg_reg < n_eff) ? seg_reg : n_eff - 9'd1;

    assign ram_we    = s_accept && (s_tuser[0] == MODE_LOAD)
                       && (32'(s_tdata[7:0]) < 32'(MAX_SEGMENTS));
    assign ram_waddr = AW'(s_tdata[7:0]);
    assign ram_wdata = {s_tdata[47:32], s_tdata[31:8]};
    assign ram_raddr = (state_reg == S_WRD) ? AW'(i_reg) : AW'(lim_idx);

    idm_ram #(
        .Width (40),
        .Depth (MAX_SEGMENTS),
        .AddrW (AW)
    ) u_route_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    idm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .stat     (div_stat),
        .quotient (quot)
    );

    //------------------------------------------------------------------
    // Arithmetic
    //------------------------------------------------------------------
    always_comb
    begin
        absdiff = (speed_reg >= vo_reg) ? speed_reg - vo_reg : vo_reg - speed_reg;
        at48    = {a_reg, 8'd0};
        if (neg_reg)
        begin
            extra = (p_reg > at48) ? 49'd0 : {1'b0, at48 - p_reg};
        end
        else
        begin
            extra = {1'b0, at48} + {1'b0, p_reg};
        end
        gap_sum = {2'd0, min_gap_reg} + {1'b0, extra[48:24]};

        r_sq    = quot[23:0] * quot[23:0];
        r4_full = r2_reg * r2_reg;
        pv_r4   = (r4_full[63:16] > {14'd0, PEN_CAP}) ? PEN_CAP : r4_full[49:16];
        q_sq    = quot[24:0] * quot[24:0];
        pg_q2   = (q_sq[49:16] > PEN_CAP) ? PEN_CAP : q_sq[49:16];

        f_next  = 36'sd65536 - $signed({2'b0, pv_reg}) - $signed({2'b0, pg_reg});

        // floor of a * f / 2^16, held at -v
        prod     = $signed({1'b0, accel_reg}) * f_reg;
        sh       = prod[52:16];
        negv     = -$signed({21'd0, speed_reg});
        upd_c    = (sh < negv) ? negv : sh;
        upd_next = upd_c[17:0];

        base       = {2'd0, speed_reg, 1'b0} + {upd_reg[17], upd_reg};
        adv_next   = base[17:0] * dt_reg;
        ns         = {3'd0, speed_reg} + {upd_reg[17], upd_reg};
        speed_next = (ns[18:16] != 3'd0) ? 16'hFFFF : ns[15:0];

        len      = ram_rdata[23:0];
        rem_frac = 17'h10000 - {1'b0, prog_reg};
        d_val    = first_reg ? {41'(rem_frac) * 41'(len), 1'b0} : {1'b0, len, 17'd0};
        d_gt     = d_val > {8'd0, adv_reg};
    end

    //------------------------------------------------------------------
    // Sequencer
    //------------------------------------------------------------------
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = (s_tuser[0] == MODE_STEP) ? S_MUL1 : S_DONE;
                end
            end
            S_MUL1:   state_next = S_MUL2;
            S_MUL2:   state_next = S_GAP;
            S_GAP:
            begin
                if (n_eff == 9'd0 || lim_reg == 16'd0)
                begin
                    state_next = S_QSTART;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {10'd0, speed_reg, 16'd0};
                    div_req.divisor  = {9'd0, lim_reg};
                    state_next       = S_RDIV;
                end
            end
            S_RDIV:
            begin
                if (div_stat.done)
                begin
                    state_next = (quot[DIVN_W-1:24] != '0) ? S_QSTART : S_R2;
                end
            end
            S_R2:     state_next = S_R4;
            S_R4:     state_next = S_QSTART;
            S_QSTART:
            begin
                if (dist_reg == 24'd0)
                begin
                    state_next = S_F;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {gap_reg, 16'd0};
                    div_req.divisor  = {1'b0, dist_reg};
                    state_next       = S_QDIV;
                end
            end
            S_QDIV:
            begin
                if (div_stat.done)
                begin
                    state_next = (quot[DIVN_W-1:25] != '0) ? S_F : S_Q2;
                end
            end
            S_Q2:     state_next = S_F;
            S_F:      state_next = S_UPD;
            S_UPD:    state_next = S_ADV;
            S_ADV:    state_next = S_WRD;
            S_WRD:    state_next = (i_reg < n_eff) ? S_WCHK : S_DONE;
            S_WCHK:
            begin
                if (d_gt)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {8'd0, adv_reg};
                    div_req.divisor  = {len, 1'b0};
                    state_next       = S_WDIV;
                end
                else
                begin
                    state_next = S_WRD;
                end
            end
            S_WDIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // car state and walk control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg    <= 16'd0;
            prog_reg     <= 16'd0;
            seg_reg      <= 9'd0;
            i_reg        <= 9'd0;
            first_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_ADV:
                begin
                    speed_reg <= speed_next;
                    i_reg     <= seg_reg;
                    first_reg <= 1'b1;
                end
                S_WRD:
                begin
                    if (i_reg >= n_eff)
                    begin
                        seg_reg <= n_eff;
                    end
                end
                S_WCHK:
                begin
                    if (!d_gt)
                    begin
                        i_reg     <= i_reg + 9'd1;
                        first_reg <= 1'b0;
                    end
                end
                S_WDIV:
                begin
                    if (div_stat.done)
                    begin
                        prog_reg <= first_reg ? prog_reg + quot[15:0] : quot[15:0];
                        seg_reg  <= i_reg;
                    end
                end
                default: ;
            endcase

            if (state_reg == S_DONE && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                dist_reg <= s_tdata[71:48];
                vo_reg   <= s_tdata[87:72];
            end
            S_MUL1:
            begin
                a_reg   <= speed_reg * react_reg;
                b_reg   <= speed_reg * brake_reg;
                neg_reg <= speed_reg < vo_reg;
            end
            S_MUL2:
            begin
                p_reg   <= b_reg * absdiff;
                lim_reg <= ram_rdata[39:24];
            end
            S_GAP:
            begin
                gap_reg <= gap_sum;
                pv_reg  <= PEN_CAP;
            end
            S_RDIV:   r2_reg  <= r_sq[47:16];
            S_R4:     pv_reg  <= pv_r4;
            S_QSTART: pg_reg  <= PEN_CAP;
            S_Q2:     pg_reg  <= pg_q2;
            S_F:      f_reg   <= f_next;
            S_UPD:    upd_reg <= upd_next;
            S_ADV:    adv_reg <= adv_next;
            S_WCHK:
            begin
                if (!d_gt)
                begin
                    adv_reg <= adv_reg - d_val[33:0];
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_data_reg <= {6'd0, (seg_reg < n_eff), seg_reg, prog_reg, speed_reg};
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_walk_in_route: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WCHK) |-> (i_reg < n_eff))
        else $error("route walk read past the route");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside completion");

endmodule

`default_nettype wire
